### rtl/core/terrain_quad_brush_elevate_defines.svh
// ----------------------------------------------------------------------------
// terrain quad brush elevate assertion macros
// shared property forms for the block's checks
// ----------------------------------------------------------------------------
`ifndef TERRAIN_QUAD_BRUSH_ELEVATE_DEFINES_SVH
`define TERRAIN_QUAD_BRUSH_ELEVATE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TQBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define TQBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/tqbe_pkg.sv
// ----------------------------------------------------------------------------
// tqbe_pkg
// types, widths and latencies shared by the brush elevate block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tqbe_pkg;

  localparam int CW    = 24;          // coordinate and height width
  localparam int RW    = 23;          // radius width
  localparam int R2W   = 2 * RW;      // squared radius
  localparam int NW    = 16;          // normal component width
  localparam int DW    = CW + 1;      // difference width
  localparam int PW    = 2 * DW;      // product width
  localparam int XW    = PW + 1;      // cross component width
  localparam int MW    = XW - 1;      // cross magnitude width
  localparam int AW    = 30;          // normalized magnitude width
  localparam int SW    = 2 * AW + 2;  // sum of squares width
  localparam int LW    = AW + 1;      // length width
  localparam int QW    = 15;          // quotient width
  localparam int NUMW  = AW + QW + 1; // dividend width
  localparam int DVW   = LW + 1;      // divisor width
  localparam int SHW   = 5;           // normalizing shift width
  localparam int IXW   = 2;           // register index width
  localparam int LANES = 4;

  localparam int LANE_LAT  = 3;
  localparam int FRONT_LAT = 8;
  localparam int NRM_LAT   = FRONT_LAT + LW + QW + 1;
  localparam int TOT_LAT   = LANE_LAT + NRM_LAT + 1;

  localparam logic [IXW-1:0] REG_CX     = 2'd0;
  localparam logic [IXW-1:0] REG_CZ     = 2'd1;
  localparam logic [IXW-1:0] REG_RADIUS = 2'd2;
  localparam logic [IXW-1:0] REG_RAISE  = 2'd3;

  localparam logic signed [CW-1:0] HMAX    = 24'sh7FFFFF;
  localparam logic signed [CW-1:0] HMIN    = 24'sh800000;
  localparam logic signed [NW-1:0] NRM_ONE = 16'sd16384;

  typedef struct packed {
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_height;
    logic signed [CW-1:0] v0_z;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_height;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_height;
    logic signed [CW-1:0] v2_z;
    logic signed [CW-1:0] v3_x;
    logic signed [CW-1:0] v3_height;
    logic signed [CW-1:0] v3_z;
  } in_word_t;

  typedef struct packed {
    logic signed [CW-1:0] new_height0;
    logic signed [CW-1:0] new_height1;
    logic signed [CW-1:0] new_height2;
    logic signed [CW-1:0] new_height3;
    logic signed [NW-1:0] first_normal_x;
    logic signed [NW-1:0] first_normal_y;
    logic signed [NW-1:0] first_normal_z;
    logic signed [NW-1:0] second_normal_x;
    logic signed [NW-1:0] second_normal_y;
    logic signed [NW-1:0] second_normal_z;
  } out_word_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] h;
    logic signed [CW-1:0] z;
  } vtx_t;

  typedef struct packed {
    logic signed [NW-1:0] x;
    logic signed [NW-1:0] y;
    logic signed [NW-1:0] z;
  } nrm_t;

endpackage

### rtl/core/tqbe_lane.sv
// ----------------------------------------------------------------------------
// tqbe_lane
// one vertex: radius test against the brush and saturated raise
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tqbe_lane (
  input  logic                          clk,
  input  tqbe_pkg::vtx_t                vtx_i,
  input  logic signed [tqbe_pkg::CW-1:0] cx,
  input  logic signed [tqbe_pkg::CW-1:0] cz,
  input  logic [tqbe_pkg::R2W-1:0]      r2,
  input  logic signed [tqbe_pkg::CW-1:0] raise,
  output tqbe_pkg::vtx_t                vtx_o
);
  import tqbe_pkg::*;

  vtx_t                 s1_r, s2_r, out_r;
  logic signed [DW-1:0] dx_r, dz_r;
  logic signed [PW-1:0] sqx_r, sqz_r;
  logic [PW:0]          d2;
  logic signed [DW-1:0] hsum;
  logic signed [CW-1:0] hsat;
  logic                 inside_brush;

  always_ff @(posedge clk) begin
    s1_r  <= vtx_i;
    dx_r  <= {vtx_i.x[CW-1], vtx_i.x} - {cx[CW-1], cx};
    dz_r  <= {vtx_i.z[CW-1], vtx_i.z} - {cz[CW-1], cz};
    s2_r  <= s1_r;
    sqx_r <= dx_r * dx_r;
    sqz_r <= dz_r * dz_r;
    out_r <= s2_r;
    if (inside_brush) begin
      out_r.h <= hsat;
    end
  end

  always_comb begin
    d2           = {1'b0, sqx_r} + {1'b0, sqz_r};
    inside_brush = d2 <= {{(PW + 1 - R2W){1'b0}}, r2};
    hsum         = {s2_r.h[CW-1], s2_r.h} + {raise[CW-1], raise};
    if (hsum[DW-1] != hsum[DW-2]) begin
      hsat = hsum[DW-1] ? HMIN : HMAX;
    end else begin
      hsat = hsum[CW-1:0];
    end
  end

  assign vtx_o = out_r;

endmodule

### rtl/core/tqbe_normal.sv
// ----------------------------------------------------------------------------
// tqbe_normal
// pipelined unit normal of one triangle: cross product, normalize,
// bit-per-stage square root and bit-per-stage divide
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tqbe_normal (
  input  logic           clk,
  input  tqbe_pkg::vtx_t p,
  input  tqbe_pkg::vtx_t q,
  input  tqbe_pkg::vtx_t r,
  output tqbe_pkg::nrm_t nrm_o
);
  import tqbe_pkg::*;

  // front stages
  logic signed [DW-1:0] a_r [3];
  logic signed [DW-1:0] b_r [3];
  logic signed [PW-1:0] pr_r [6];
  logic signed [XW-1:0] c_r [3];
  logic [MW-1:0]        mag_r [3];
  logic [MW-1:0]        mag5_r [3];
  logic [MW-1:0]        or_r;
  logic [2:0]           ng4_r, ng5_r, ng6_r, ng7_r, ng8_r;
  logic [SHW-1:0]       sh, sh_r;
  logic [AW-1:0]        a6_r [3];
  logic [AW-1:0]        a7_r [3];
  logic [AW-1:0]        a8_r [3];
  logic [2*AW-1:0]      sq_r [3];
  logic [SW-1:0]        sum_r;

  // square root stages
  logic [SW-1:0] rm_r   [LW];
  logic [LW-1:0] rt_r   [LW];
  logic [AW-1:0] ma_r   [LW][3];
  logic [2:0]    sg_r   [LW];
  logic [SW-1:0] rm_in  [LW];
  logic [LW-1:0] rt_in  [LW];
  logic [SW-1:0] rm_nxt [LW];
  logic [LW-1:0] rt_nxt [LW];

  // divide stages
  logic [NUMW-1:0] dr_r   [QW][3];
  logic [QW-1:0]   dq_r   [QW][3];
  logic [DVW-1:0]  dd_r   [QW];
  logic [2:0]      ds_r   [QW];
  logic            dz_r   [QW];
  logic [NUMW-1:0] dr_in  [QW][3];
  logic [QW-1:0]   dq_in  [QW][3];
  logic [DVW-1:0]  dd_in  [QW];
  logic [2:0]      ds_in  [QW];
  logic            dz_in  [QW];
  logic [NUMW-1:0] dr_nxt [QW][3];
  logic [QW-1:0]   dq_nxt [QW][3];

  nrm_t nrm_r;
  nrm_t nrm_nxt;

  always_ff @(posedge clk) begin
    a_r[0] <= {p.x[CW-1], p.x} - {q.x[CW-1], q.x};
    a_r[1] <= {p.h[CW-1], p.h} - {q.h[CW-1], q.h};
    a_r[2] <= {p.z[CW-1], p.z} - {q.z[CW-1], q.z};
    b_r[0] <= {p.x[CW-1], p.x} - {r.x[CW-1], r.x};
    b_r[1] <= {p.h[CW-1], p.h} - {r.h[CW-1], r.h};
    b_r[2] <= {p.z[CW-1], p.z} - {r.z[CW-1], r.z};
    pr_r[0] <= a_r[1] * b_r[2];
    pr_r[1] <= a_r[2] * b_r[1];
    pr_r[2] <= a_r[2] * b_r[0];
    pr_r[3] <= a_r[0] * b_r[2];
    pr_r[4] <= a_r[0] * b_r[1];
    pr_r[5] <= a_r[1] * b_r[0];
    c_r[0] <= XW'(pr_r[0]) - XW'(pr_r[1]);
    c_r[1] <= XW'(pr_r[2]) - XW'(pr_r[3]);
    c_r[2] <= XW'(pr_r[4]) - XW'(pr_r[5]);
    for (int i = 0; i < 3; i++) begin
      mag_r[i]  <= MW'(c_r[i][XW-1] ? -c_r[i] : c_r[i]);
      ng4_r[i]  <= c_r[i][XW-1];
      mag5_r[i] <= mag_r[i];
      a6_r[i]   <= AW'(mag5_r[i] >> sh_r);
      a7_r[i]   <= a6_r[i];
      sq_r[i]   <= a6_r[i] * a6_r[i];
      a8_r[i]   <= a7_r[i];
    end
    or_r  <= MW'(c_r[0][XW-1] ? -c_r[0] : c_r[0])
           | MW'(c_r[1][XW-1] ? -c_r[1] : c_r[1])
           | MW'(c_r[2][XW-1] ? -c_r[2] : c_r[2]);
    sh_r  <= sh;
    ng5_r <= ng4_r;
    ng6_r <= ng5_r;
    ng7_r <= ng6_r;
    ng8_r <= ng7_r;
    sum_r <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
    for (int k = 0; k < LW; k++) begin
      rm_r[k] <= rm_nxt[k];
      rt_r[k] <= rt_nxt[k];
    end
    ma_r[0] <= a8_r;
    sg_r[0] <= ng8_r;
    for (int k = 1; k < LW; k++) begin
      ma_r[k] <= ma_r[k-1];
      sg_r[k] <= sg_r[k-1];
    end
    for (int j = 0; j < QW; j++) begin
      dr_r[j] <= dr_nxt[j];
      dq_r[j] <= dq_nxt[j];
      dd_r[j] <= dd_in[j];
      ds_r[j] <= ds_in[j];
      dz_r[j] <= dz_in[j];
    end
    nrm_r <= nrm_nxt;
  end

  // normalizing shift from the leading one above the kept window
  always_comb begin
    sh = '0;
    for (int i = AW; i < MW; i++) begin
      if (or_r[i]) begin
        sh = SHW'(i - AW + 1);
      end
    end
  end

  // square root, one result bit per stage
  always_comb begin
    logic [SW+1:0] tr;
    rm_in[0] = sum_r;
    rt_in[0] = '0;
    for (int k = 1; k < LW; k++) begin
      rm_in[k] = rm_r[k-1];
      rt_in[k] = rt_r[k-1];
    end
    for (int k = 0; k < LW; k++) begin
      tr = ({{(SW + 2 - LW){1'b0}}, rt_in[k]} << (LW - k))
         | ((SW + 2)'(1) << (2 * (LW - 1 - k)));
      if ({2'b00, rm_in[k]} >= tr) begin
        rm_nxt[k] = SW'({2'b00, rm_in[k]} - tr);
        rt_nxt[k] = rt_in[k] | (LW'(1) << (LW - 1 - k));
      end else begin
        rm_nxt[k] = rm_in[k];
        rt_nxt[k] = rt_in[k];
      end
    end
  end

  // rounded divide, one quotient bit per stage
  always_comb begin
    logic [NUMW:0] dt;
    for (int c = 0; c < 3; c++) begin
      dr_in[0][c] = NUMW'({ma_r[LW-1][c], {QW{1'b0}}}) + NUMW'(rt_r[LW-1]);
      dq_in[0][c] = '0;
    end
    dd_in[0] = {rt_r[LW-1], 1'b0};
    ds_in[0] = sg_r[LW-1];
    dz_in[0] = rt_r[LW-1] == '0;
    for (int j = 1; j < QW; j++) begin
      dr_in[j] = dr_r[j-1];
      dq_in[j] = dq_r[j-1];
      dd_in[j] = dd_r[j-1];
      ds_in[j] = ds_r[j-1];
      dz_in[j] = dz_r[j-1];
    end
    for (int j = 0; j < QW; j++) begin
      dt = (NUMW + 1)'(dd_in[j]) << (QW - 1 - j);
      for (int c = 0; c < 3; c++) begin
        if ({1'b0, dr_in[j][c]} >= dt) begin
          dr_nxt[j][c] = NUMW'({1'b0, dr_in[j][c]} - dt);
          dq_nxt[j][c] = dq_in[j][c] | (QW'(1) << (QW - 1 - j));
        end else begin
          dr_nxt[j][c] = dr_in[j][c];
          dq_nxt[j][c] = dq_in[j][c];
        end
      end
    end
  end

  always_comb begin
    logic signed [NW-1:0] v [3];
    for (int c = 0; c < 3; c++) begin
      v[c] = {1'b0, dq_r[QW-1][c]};
      if (dz_r[QW-1]) begin
        v[c] = '0;
      end else if (ds_r[QW-1][c]) begin
        v[c] = -v[c];
      end
    end
    nrm_nxt.x = v[0];
    nrm_nxt.y = v[1];
    nrm_nxt.z = v[2];
  end

  assign nrm_o = nrm_r;

endmodule

### rtl/core/terrain_quad_brush_elevate.sv
// ----------------------------------------------------------------------------
// terrain_quad_brush_elevate
// raises the vertices of one quad inside a circular brush and forms the
// two triangle normals of the result
// throughput: one quad per cycle, busy never rises; the receiver cannot stall
// the pipeline holds a square root (31 stages) and a divider (15 stages)
// reset: rst_n synchronous low clears the brush registers and valid pipeline to zero and drops words in flight
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "terrain_quad_brush_elevate_defines.svh"

module terrain_quad_brush_elevate (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  tqbe_pkg::in_word_t          in_data,
  output logic                        out_valid,
  output tqbe_pkg::out_word_t         out_data,
  input  logic                        cfg_we,
  input  logic [tqbe_pkg::IXW-1:0]    cfg_index,
  input  logic [tqbe_pkg::CW-1:0]     cfg_wdata
);
  import tqbe_pkg::*;

  logic signed [CW-1:0] cx_r, cz_r, raise_r;
  logic [RW-1:0]        radius_r;
  logic [R2W-1:0]       r2_r;
  logic [TOT_LAT-1:0]   vld_r;
  logic                 accept;
  vtx_t                 vin [LANES];
  vtx_t                 vout [LANES];
  nrm_t                 n1, n2;
  logic signed [CW-1:0] hd_r [NRM_LAT][LANES];
  out_word_t            out_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cz_r     <= '0;
      radius_r <= '0;
      raise_r  <= '0;
      vld_r    <= '0;
    end else begin
      vld_r <= {vld_r[TOT_LAT-2:0], accept};
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CX:     cx_r     <= cfg_wdata;
          REG_CZ:     cz_r     <= cfg_wdata;
          REG_RADIUS: radius_r <= cfg_wdata[RW-1:0];
          REG_RAISE:  raise_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    r2_r <= radius_r * radius_r;
    for (int l = 0; l < LANES; l++) begin
      hd_r[0][l] <= vout[l].h;
    end
    for (int k = 1; k < NRM_LAT; k++) begin
      hd_r[k] <= hd_r[k-1];
    end
    out_r.new_height0     <= hd_r[NRM_LAT-1][0];
    out_r.new_height1     <= hd_r[NRM_LAT-1][1];
    out_r.new_height2     <= hd_r[NRM_LAT-1][2];
    out_r.new_height3     <= hd_r[NRM_LAT-1][3];
    out_r.first_normal_x  <= n1.x;
    out_r.first_normal_y  <= n1.y;
    out_r.first_normal_z  <= n1.z;
    out_r.second_normal_x <= n2.x;
    out_r.second_normal_y <= n2.y;
    out_r.second_normal_z <= n2.z;
  end

  assign vin[0] = '{x: in_data.v0_x, h: in_data.v0_height, z: in_data.v0_z};
  assign vin[1] = '{x: in_data.v1_x, h: in_data.v1_height, z: in_data.v1_z};
  assign vin[2] = '{x: in_data.v2_x, h: in_data.v2_height, z: in_data.v2_z};
  assign vin[3] = '{x: in_data.v3_x, h: in_data.v3_height, z: in_data.v3_z};

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    tqbe_lane u_lane (
      .clk   (clk),
      .vtx_i (vin[l]),
      .cx    (cx_r),
      .cz    (cz_r),
      .r2    (r2_r),
      .raise (raise_r),
      .vtx_o (vout[l])
    );
  end

  tqbe_normal u_first (
    .clk   (clk),
    .p     (vout[0]),
    .q     (vout[1]),
    .r     (vout[2]),
    .nrm_o (n1)
  );

  tqbe_normal u_second (
    .clk   (clk),
    .p     (vout[2]),
    .q     (vout[3]),
    .r     (vout[0]),
    .nrm_o (n2)
  );

  assign out_valid = vld_r[TOT_LAT-1];
  assign out_data  = out_r;

  `TQBE_ASSERT_NOW(a_out_from_start, out_valid, $past(accept, TOT_LAT), "word out without start")
  `TQBE_ASSERT_NEXT(a_start_tracked, accept, vld_r[0], "accepted word not tracked")
  `TQBE_ASSERT_NOW(a_first_range, out_valid, (out_data.first_normal_x <= NRM_ONE) && (out_data.first_normal_x >= -NRM_ONE) && (out_data.first_normal_y <= NRM_ONE) && (out_data.first_normal_y >= -NRM_ONE), "first normal out of range")
  `TQBE_ASSERT_NOW(a_second_range, out_valid, (out_data.second_normal_x <= NRM_ONE) && (out_data.second_normal_x >= -NRM_ONE) && (out_data.second_normal_y <= NRM_ONE) && (out_data.second_normal_y >= -NRM_ONE), "second normal out of range")

endmodule
